@@ src/aho_corasick_multi_pattern_counter_core_assert.svh @@
// Assertion macros shared by the checker of the matcher core.
// Depends on a clk and an active-low rst_n in the including scope.
`ifndef AHO_CORASICK_MULTI_PATTERN_COUNTER_CORE_ASSERT_SVH
`define AHO_CORASICK_MULTI_PATTERN_COUNTER_CORE_ASSERT_SVH

// same-cycle implication
`define ACO_AST_IMP(name, ante, cons, msg) \
  name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication
`define ACO_AST_NXT(name, ante, cons, msg) \
  name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

@@ src/aco_pkg.sv @@
// Shared types, constants and helpers for the multi-pattern matcher core.
// No dependencies.
package aco_pkg;

  localparam int MAX_NODES     = 4096;
  localparam int ALPHABET_SIZE = 26;
  localparam int NODE_W        = $clog2(MAX_NODES);
  localparam int USED_W        = $clog2(MAX_NODES + 1);
  localparam int SYM_W         = 5;
  localparam int CNT_W         = 16;
  localparam int TOT_W         = 32;
  localparam int CT_DEPTH      = MAX_NODES * ALPHABET_SIZE;
  localparam int CT_AW         = $clog2(CT_DEPTH);

  localparam logic STATUS_OK   = 1'b0;
  localparam logic STATUS_FULL = 1'b1;

  typedef enum logic [1:0] {
    OP_CLEAR  = 2'd0,
    OP_INSERT = 2'd1,
    OP_BUILD  = 2'd2,
    OP_QUERY  = 2'd3
  } op_t;

  typedef enum logic [4:0] {
    ST_INIT, ST_IDLE, ST_DISP,
    ST_INS_RD, ST_INS_END, ST_INS_BUMP,
    ST_Q_LOOK, ST_Q_CHK, ST_Q_ADD, ST_Q_SUM,
    ST_B_POP, ST_B_PNODE, ST_B_PFAIL, ST_B_CRD, ST_B_CCHK,
    ST_B_TRD, ST_B_TCHK, ST_B_FOLD, ST_B_FOLD2, ST_B_FOLD3,
    ST_RESP
  } state_t;

  typedef struct packed {
    logic [NODE_W-1:0] fail;
    logic [CNT_W-1:0]  cnt;
  } node_t;

  function automatic logic [CT_AW-1:0] slot_addr(input logic [NODE_W-1:0] node,
                                                 input logic [SYM_W-1:0] sym);
    slot_addr = CT_AW'(node) * CT_AW'(ALPHABET_SIZE) + CT_AW'(sym);
  endfunction

  function automatic logic [CNT_W-1:0] sat_add16(input logic [CNT_W-1:0] a,
                                                 input logic [CNT_W-1:0] b);
    logic [CNT_W:0] s;
    s = {1'b0, a} + {1'b0, b};
    sat_add16 = s[CNT_W] ? {CNT_W{1'b1}} : s[CNT_W-1:0];
  endfunction

  function automatic logic [TOT_W-1:0] sat_add32(input logic [TOT_W-1:0] a,
                                                 input logic [CNT_W-1:0] b);
    logic [TOT_W:0] s;
    s = {1'b0, a} + (TOT_W + 1)'(b);
    sat_add32 = s[TOT_W] ? {TOT_W{1'b1}} : s[TOT_W-1:0];
  endfunction

endpackage

@@ src/aco_ram.sv @@
// Generic single-write, single-read synchronous RAM, registered read data.
// No dependencies.
module aco_ram #(
  parameter int DEPTH = 4096,
  parameter int WIDTH = 12,
  localparam int AW   = $clog2(DEPTH)
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    rdata <= mem[raddr];
  end

endmodule

@@ src/aho_corasick_multi_pattern_counter_core.sv @@
// Top level of the Aho-Corasick multi-pattern occurrence counter.
// Depends on aco_pkg and aco_ram.
//
//  channel | ports                                   | transfer when
//  --------+-----------------------------------------+----------------------
//  in      | in_opcode, in_symbol, in_last           | in_valid & in_ready
//  out     | out_status, out_match_count, out_text_done | out_valid & out_ready
//
// One item is worked at a time; every item gives one result.
// Query letter: failure links are followed from the current node until the
// letter has a child or the root is reached (child table and node store reads
// are registered); an out-of-range letter skips the lookup.
// Insert: an end count may be bumped, and a node may be allocated (its 26 child
// slots are zeroed one per cycle). Clear zeroes the root's child slots.
// Build: nodes are taken breadth first and each one's 26 child slots are read in
// turn; every child below the root's children follows further failure hops.
// After reset the root's child slots are zeroed while in_ready stays low.
// A result waiting on out_ready holds; a new item is still taken meanwhile.
module aho_corasick_multi_pattern_counter_core
  import aco_pkg::*;
(
  input  logic                    clk,
  input  logic                    rst_n,
  input  logic                    in_valid,
  output logic                    in_ready,
  input  logic [1:0]              in_opcode,
  input  logic [SYM_W-1:0]        in_symbol,
  input  logic                    in_last,
  output logic                    out_valid,
  input  logic                    out_ready,
  output logic                    out_status,
  output logic [TOT_W-1:0]        out_match_count,
  output logic                    out_text_done
);

  localparam logic [USED_W-1:0] MAX_USED  = USED_W'(MAX_NODES);
  localparam logic [SYM_W-1:0]  ALPHA     = SYM_W'(ALPHABET_SIZE);
  localparam logic [SYM_W-1:0]  ALPHA_TOP = SYM_W'(ALPHABET_SIZE - 1);

  // control state
  state_t              state_r, state_nxt, ret_r, ret_nxt;
  logic [SYM_W-1:0]    init_cnt_r, init_cnt_nxt;
  logic [NODE_W-1:0]   init_node_r, init_node_nxt;
  logic [USED_W-1:0]   nodes_used_r, nodes_used_nxt;
  logic [NODE_W-1:0]   ins_cur_r, ins_cur_nxt;
  logic [NODE_W-1:0]   mat_cur_r, mat_cur_nxt;
  logic [TOT_W-1:0]    total_r, total_nxt;
  logic                out_valid_r, out_valid_nxt;

  // working registers
  op_t                 op_r, op_nxt;
  logic [SYM_W-1:0]    sym_r, sym_nxt;
  logic                last_r, last_nxt;
  logic [NODE_W-1:0]   p_r, p_nxt, t_r, t_nxt, c_r, c_nxt, f_r, f_nxt, pf_r, pf_nxt;
  logic [SYM_W-1:0]    i_r, i_nxt;
  logic [USED_W-1:0]   guard_r, guard_nxt, head_r, head_nxt, tail_r, tail_nxt;
  logic [CNT_W-1:0]    fcnt_r, fcnt_nxt;
  logic                bump_r, bump_nxt;
  logic                res_status_r, res_status_nxt, res_done_r, res_done_nxt;
  logic [TOT_W-1:0]    res_count_r, res_count_nxt, sum;
  logic                out_status_r, out_status_nxt, out_done_r, out_done_nxt;
  logic [TOT_W-1:0]    out_count_r, out_count_nxt;

  // memory ports
  logic                ct_we;
  logic [CT_AW-1:0]    ct_waddr, ct_raddr;
  logic [NODE_W-1:0]   ct_wdata, ct_rdata;
  logic                nd_we;
  logic [NODE_W-1:0]   nd_waddr, nd_raddr;
  node_t               nd_wdata, nd_rdata;
  logic                q_we;
  logic [NODE_W-1:0]   q_waddr, q_raddr, q_wdata, q_rdata;

  logic                sym_ok;

  // child table: node*26+letter -> child, 0 = none
  aco_ram #(.DEPTH(CT_DEPTH), .WIDTH(NODE_W)) u_child (
    .clk, .we(ct_we), .waddr(ct_waddr), .wdata(ct_wdata),
    .raddr(ct_raddr), .rdata(ct_rdata)
  );

  // node store: failure link and end count per node
  aco_ram #(.DEPTH(MAX_NODES), .WIDTH($bits(node_t))) u_node (
    .clk, .we(nd_we), .waddr(nd_waddr), .wdata(nd_wdata),
    .raddr(nd_raddr), .rdata(nd_rdata)
  );

  // breadth-first work queue for build
  aco_ram #(.DEPTH(MAX_NODES), .WIDTH(NODE_W)) u_queue (
    .clk, .we(q_we), .waddr(q_waddr), .wdata(q_wdata),
    .raddr(q_raddr), .rdata(q_rdata)
  );

  assign sym_ok          = sym_r < ALPHA;
  assign in_ready        = (state_r == ST_IDLE);
  assign out_valid       = out_valid_r;
  assign out_status      = out_status_r;
  assign out_match_count = out_count_r;
  assign out_text_done   = out_done_r;
  assign sum             = sat_add32(total_r, nd_rdata.cnt);

  always_comb begin
    state_nxt      = state_r;
    ret_nxt        = ret_r;
    init_cnt_nxt   = init_cnt_r;
    init_node_nxt  = init_node_r;
    nodes_used_nxt = nodes_used_r;
    ins_cur_nxt    = ins_cur_r;
    mat_cur_nxt    = mat_cur_r;
    total_nxt      = total_r;
    op_nxt         = op_r;
    sym_nxt        = sym_r;
    last_nxt       = last_r;
    p_nxt          = p_r;
    t_nxt          = t_r;
    c_nxt          = c_r;
    f_nxt          = f_r;
    pf_nxt         = pf_r;
    i_nxt          = i_r;
    guard_nxt      = guard_r;
    head_nxt       = head_r;
    tail_nxt       = tail_r;
    fcnt_nxt       = fcnt_r;
    bump_nxt       = bump_r;
    res_status_nxt = res_status_r;
    res_count_nxt  = res_count_r;
    res_done_nxt   = res_done_r;
    out_status_nxt = out_status_r;
    out_count_nxt  = out_count_r;
    out_done_nxt   = out_done_r;
    out_valid_nxt  = out_valid_r && !out_ready;

    ct_we    = 1'b0;
    ct_waddr = slot_addr(init_node_r, init_cnt_r);
    ct_wdata = '0;
    ct_raddr = slot_addr(p_r, sym_r);
    nd_we    = 1'b0;
    nd_waddr = init_node_r;
    nd_wdata = '0;
    nd_raddr = p_r;
    q_we     = 1'b0;
    q_waddr  = tail_r[NODE_W-1:0];
    q_wdata  = c_r;
    q_raddr  = head_r[NODE_W-1:0];

    unique case (state_r)
      // zero a fresh node: one child slot per cycle, node entry on the first
      ST_INIT: begin
        ct_we = 1'b1;
        nd_we = (init_cnt_r == '0);
        if (init_cnt_r == ALPHA_TOP) begin
          init_cnt_nxt = '0;
          state_nxt    = ret_r;
        end else begin
          init_cnt_nxt = init_cnt_r + 1'b1;
        end
      end

      ST_IDLE: begin
        if (in_valid) begin
          op_nxt         = op_t'(in_opcode);
          sym_nxt        = in_symbol;
          last_nxt       = in_last;
          res_status_nxt = STATUS_OK;
          res_count_nxt  = '0;
          res_done_nxt   = 1'b0;
          state_nxt      = ST_DISP;
        end
      end

      ST_DISP: begin
        unique case (op_r)
          OP_CLEAR: begin
            nodes_used_nxt = USED_W'(1);
            ins_cur_nxt    = '0;
            mat_cur_nxt    = '0;
            total_nxt      = '0;
            init_node_nxt  = '0;
            init_cnt_nxt   = '0;
            ret_nxt        = ST_RESP;
            state_nxt      = ST_INIT;
          end
          OP_INSERT: begin
            bump_nxt = 1'b0;
            ct_raddr = slot_addr(ins_cur_r, sym_r);
            state_nxt = sym_ok ? ST_INS_RD : ST_INS_END;
          end
          OP_BUILD: begin
            q_we      = 1'b1;
            q_waddr   = '0;
            q_wdata   = '0;
            head_nxt  = '0;
            tail_nxt  = USED_W'(1);
            state_nxt = ST_B_POP;
          end
          OP_QUERY: begin
            guard_nxt = '0;
            if (sym_ok) begin
              p_nxt     = mat_cur_r;
              state_nxt = ST_Q_LOOK;
            end else begin
              p_nxt     = '0;
              state_nxt = ST_Q_ADD;
            end
          end
          default: state_nxt = ST_RESP;
        endcase
      end

      ST_INS_RD: begin
        if (ct_rdata != '0) begin
          ins_cur_nxt = ct_rdata;
          bump_nxt    = 1'b1;
          state_nxt   = ST_INS_END;
        end else if (nodes_used_r < MAX_USED) begin
          ct_we          = 1'b1;
          ct_waddr       = slot_addr(ins_cur_r, sym_r);
          ct_wdata       = nodes_used_r[NODE_W-1:0];
          nodes_used_nxt = nodes_used_r + 1'b1;
          ins_cur_nxt    = nodes_used_r[NODE_W-1:0];
          bump_nxt       = 1'b1;
          init_node_nxt  = nodes_used_r[NODE_W-1:0];
          init_cnt_nxt   = '0;
          ret_nxt        = ST_INS_END;
          state_nxt      = ST_INIT;
        end else begin
          res_status_nxt = STATUS_FULL;
          state_nxt      = ST_INS_END;
        end
      end

      ST_INS_END: begin
        nd_raddr = ins_cur_r;
        if (last_r && bump_r) begin
          state_nxt = ST_INS_BUMP;
        end else begin
          if (last_r) begin
            ins_cur_nxt = '0;
          end
          state_nxt = ST_RESP;
        end
      end

      ST_INS_BUMP: begin
        nd_we       = 1'b1;
        nd_waddr    = ins_cur_r;
        nd_wdata    = '{fail: nd_rdata.fail, cnt: sat_add16(nd_rdata.cnt, CNT_W'(1))};
        ins_cur_nxt = '0;
        state_nxt   = ST_RESP;
      end

      // follow failure links until the letter has an edge or root is hit (or the hop guard runs out)
      ST_Q_LOOK: begin
        state_nxt = ST_Q_CHK;
      end

      ST_Q_CHK: begin
        if (ct_rdata != '0) begin
          p_nxt     = ct_rdata;
          state_nxt = ST_Q_ADD;
        end else if (p_r == '0) begin
          state_nxt = ST_Q_ADD;
        end else if (guard_r < MAX_USED) begin
          guard_nxt = guard_r + 1'b1;
          p_nxt     = nd_rdata.fail;
          state_nxt = ST_Q_LOOK;
        end else begin
          p_nxt     = '0;
          state_nxt = ST_Q_ADD;
        end
      end

      ST_Q_ADD: begin
        state_nxt = ST_Q_SUM;
      end

      ST_Q_SUM: begin
        res_count_nxt = sum;
        mat_cur_nxt   = p_r;
        total_nxt     = sum;
        if (last_r) begin
          res_done_nxt = 1'b1;
          total_nxt    = '0;
          mat_cur_nxt  = '0;
        end
        state_nxt = ST_RESP;
      end

      ST_B_POP: begin
        if (head_r < tail_r) begin
          head_nxt  = head_r + 1'b1;
          state_nxt = ST_B_PNODE;
        end else begin
          state_nxt = ST_RESP;
        end
      end

      ST_B_PNODE: begin
        p_nxt     = q_rdata;
        nd_raddr  = q_rdata;
        state_nxt = ST_B_PFAIL;
      end

      ST_B_PFAIL: begin
        pf_nxt    = nd_rdata.fail;
        i_nxt     = '0;
        state_nxt = ST_B_CRD;
      end

      ST_B_CRD: begin
        ct_raddr = slot_addr(p_r, i_r);
        state_nxt = (i_r == ALPHA) ? ST_B_POP : ST_B_CCHK;
      end

      ST_B_CCHK: begin
        if (ct_rdata == '0 || {1'b0, ct_rdata} >= nodes_used_r) begin
          i_nxt     = i_r + 1'b1;
          state_nxt = ST_B_CRD;
        end else begin
          c_nxt = ct_rdata;
          if (p_r == '0) begin
            f_nxt     = '0;
            state_nxt = ST_B_FOLD;
          end else begin
            t_nxt     = pf_r;
            guard_nxt = '0;
            state_nxt = ST_B_TRD;
          end
        end
      end

      ST_B_TRD: begin
        ct_raddr  = slot_addr(t_r, i_r);
        nd_raddr  = t_r;
        state_nxt = ST_B_TCHK;
      end

      ST_B_TCHK: begin
        if (ct_rdata != '0) begin
          f_nxt     = ct_rdata;
          state_nxt = ST_B_FOLD;
        end else if (t_r == '0 || guard_r >= MAX_USED) begin
          f_nxt     = '0;
          state_nxt = ST_B_FOLD;
        end else begin
          guard_nxt = guard_r + 1'b1;
          t_nxt     = nd_rdata.fail;
          state_nxt = ST_B_TRD;
        end
      end

      ST_B_FOLD: begin
        nd_raddr  = f_r;
        state_nxt = ST_B_FOLD2;
      end

      ST_B_FOLD2: begin
        fcnt_nxt  = nd_rdata.cnt;
        nd_raddr  = c_r;
        state_nxt = ST_B_FOLD3;
      end

      // set link, fold the failure node's count, enqueue the child if the queue has room
      ST_B_FOLD3: begin
        nd_we    = 1'b1;
        nd_waddr = c_r;
        nd_wdata = '{fail: f_r, cnt: sat_add16(nd_rdata.cnt, fcnt_r)};
        if (tail_r < MAX_USED) begin
          q_we     = 1'b1;
          tail_nxt = tail_r + 1'b1;
        end
        i_nxt     = i_r + 1'b1;
        state_nxt = ST_B_CRD;
      end

      ST_RESP: begin
        if (!out_valid_r || out_ready) begin
          out_valid_nxt  = 1'b1;
          out_status_nxt = res_status_r;
          out_count_nxt  = res_count_r;
          out_done_nxt   = res_done_r;
          state_nxt      = ST_IDLE;
        end
      end

      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= ST_INIT;
      ret_r        <= ST_IDLE;
      init_cnt_r   <= '0;
      init_node_r  <= '0;
      nodes_used_r <= USED_W'(1);
      ins_cur_r    <= '0;
      mat_cur_r    <= '0;
      total_r      <= '0;
      out_valid_r  <= 1'b0;
    end else begin
      state_r      <= state_nxt;
      ret_r        <= ret_nxt;
      init_cnt_r   <= init_cnt_nxt;
      init_node_r  <= init_node_nxt;
      nodes_used_r <= nodes_used_nxt;
      ins_cur_r    <= ins_cur_nxt;
      mat_cur_r    <= mat_cur_nxt;
      total_r      <= total_nxt;
      out_valid_r  <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    op_r         <= op_nxt;
    sym_r        <= sym_nxt;
    last_r       <= last_nxt;
    p_r          <= p_nxt;
    t_r          <= t_nxt;
    c_r          <= c_nxt;
    f_r          <= f_nxt;
    pf_r         <= pf_nxt;
    i_r          <= i_nxt;
    guard_r      <= guard_nxt;
    head_r       <= head_nxt;
    tail_r       <= tail_nxt;
    fcnt_r       <= fcnt_nxt;
    bump_r       <= bump_nxt;
    res_status_r <= res_status_nxt;
    res_count_r  <= res_count_nxt;
    res_done_r   <= res_done_nxt;
    out_status_r <= out_status_nxt;
    out_count_r  <= out_count_nxt;
    out_done_r   <= out_done_nxt;
  end

endmodule

@@ src/aco_checker.sv @@
// Port-level checker for the matcher core, bound to the top level.
// Depends on aho_corasick_multi_pattern_counter_core_assert.svh.
`include "aho_corasick_multi_pattern_counter_core_assert.svh"

module aco_checker (
  input logic        clk,
  input logic        rst_n,
  input logic        in_valid,
  input logic        in_ready,
  input logic        out_valid,
  input logic        out_ready,
  input logic        out_status,
  input logic [31:0] out_match_count,
  input logic        out_text_done
);

  // stalled result holds
  `ACO_AST_NXT(a_out_hold, out_valid && !out_ready, out_valid && $stable(out_match_count) && $stable(out_status) && $stable(out_text_done), "result changed while stalled")

  // one item in flight: a transfer in drops ready
  `ACO_AST_NXT(a_one_item, in_valid && in_ready, !in_ready, "second item taken while busy")

  // a full-store insert result carries no count and closes no text
  `ACO_AST_IMP(a_full_clean, out_valid && out_status, out_match_count == 32'd0 && !out_text_done, "full status with query fields")

endmodule

bind aho_corasick_multi_pattern_counter_core aco_checker u_aco_checker (.*);
